>>> rtl/utt_pkg.sv
package utt_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW = 21;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW = $clog2(MaxBytes);
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [UnitW-1:0] SurrHiMin = 16'hD800;
  localparam logic [UnitW-1:0] SurrHiMax = 16'hDBFF;
  localparam logic [UnitW-1:0] SurrLoMin = 16'hDC00;
  localparam logic [UnitW-1:0] SurrLoMax = 16'hDFFF;
  localparam logic [CpW-1:0] SuppBase = 21'h10000;
  localparam logic [CpW-1:0] Max1Byte = 21'h0007F;
  localparam logic [CpW-1:0] Max2Byte = 21'h007FF;
  localparam logic [CpW-1:0] Max3Byte = 21'h0FFFF;
  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] Cont = 8'h80;

  // One queued command: the bytes of one code point, or a bare bad-string status.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
    logic                           eos;
    logic                           bare;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic cmd_t encode_cp(logic [CpW-1:0] cp, logic eos);
    cmd_t c;
    c = '0;
    c.eos = eos;
    if (cp <= Max1Byte) begin
      c.bytes[0] = cp[7:0];
      c.last_idx = IdxW'(0);
    end else if (cp <= Max2Byte) begin
      c.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      c.bytes[1] = Cont | {2'b00, cp[5:0]};
      c.last_idx = IdxW'(1);
    end else if (cp <= Max3Byte) begin
      c.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
      c.bytes[1] = Cont | {2'b00, cp[11:6]};
      c.bytes[2] = Cont | {2'b00, cp[5:0]};
      c.last_idx = IdxW'(2);
    end else begin
      c.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
      c.bytes[1] = Cont | {2'b00, cp[17:12]};
      c.bytes[2] = Cont | {2'b00, cp[11:6]};
      c.bytes[3] = Cont | {2'b00, cp[5:0]};
      c.last_idx = IdxW'(3);
    end
    return c;
  endfunction

endpackage

>>> rtl/utt_if.sv
interface utt_in_if;
  import utt_pkg::*;
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] code_unit;
  logic             end_of_string;
  modport source (output valid, code_unit, end_of_string, input ready);
  modport sink (input valid, code_unit, end_of_string, output ready);
  modport mon (input valid, ready, code_unit, end_of_string);
endinterface

interface utt_out_if;
  import utt_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             has_byte;
  logic             last_of_run;
  logic             string_end;
  logic             bad_string;
  modport source (output valid, out_byte, has_byte, last_of_run, string_end, bad_string,
                  input ready);
  modport sink (input valid, out_byte, has_byte, last_of_run, string_end, bad_string,
                output ready);
  modport mon (input valid, ready, out_byte, has_byte, last_of_run, string_end, bad_string);
endinterface

>>> rtl/utt_front.sv
module utt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  utt_in_if.sink           in_i,
  input  utt_pkg::q_stat_t stat_i,
  output logic             push_o,
  output utt_pkg::cmd_t    cmd_o
);
  import utt_pkg::*;

  logic [9:0]     held_q, held_d;
  logic           pend_q, pend_d;
  logic           fail_q, fail_d;
  logic           accept;
  logic           encode;
  logic [CpW-1:0] cp;
  logic [UnitW-1:0] u;
  logic           is_low, is_high;
  cmd_t           bare_cmd;

  assign in_i.ready = !stat_i.full;
  assign accept = in_i.valid && !stat_i.full;
  assign u = in_i.code_unit;

  always_comb begin
    is_low = u inside {[SurrLoMin:SurrLoMax]};
    is_high = u inside {[SurrHiMin:SurrHiMax]};
    held_d = held_q;
    pend_d = pend_q;
    fail_d = fail_q;
    encode = 1'b0;
    cp = '0;
    if (!fail_q) begin
      if (pend_q) begin
        if (is_low) begin
          cp = SuppBase + {1'b0, held_q, u[9:0]};
          encode = 1'b1;
          pend_d = 1'b0;
          held_d = '0;
        end else begin
          fail_d = 1'b1;
        end
      end else if (u == '0 || is_low) begin
        fail_d = 1'b1;
      end else if (is_high) begin
        held_d = u[9:0];
        pend_d = 1'b1;
        if (in_i.end_of_string) begin
          fail_d = 1'b1;
        end
      end else begin
        cp = {5'b00000, u};
        encode = 1'b1;
      end
    end

    bare_cmd = '0;
    bare_cmd.eos = 1'b1;
    bare_cmd.bare = 1'b1;

    if (fail_d) begin
      push_o = accept && in_i.end_of_string;
      cmd_o = bare_cmd;
    end else begin
      push_o = accept && encode;
      cmd_o = encode_cp(cp, in_i.end_of_string);
    end

    if (in_i.end_of_string) begin
      held_d = '0;
      pend_d = 1'b0;
      fail_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pend_q <= 1'b0;
      fail_q <= 1'b0;
    end else if (accept) begin
      held_q <= held_d;
      pend_q <= pend_d;
      fail_q <= fail_d;
    end
  end

endmodule

>>> rtl/utt_queue.sv
module utt_queue #(
  parameter int unsigned Depth = utt_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utt_pkg::cmd_t    push_cmd_i,
  input  logic             pop_i,
  output utt_pkg::cmd_t    head_o,
  output utt_pkg::q_stat_t stat_o
);
  import utt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop = pop_i && !stat_o.empty;
  assign head_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/utt_back.sv
module utt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  utt_pkg::cmd_t    head_i,
  input  utt_pkg::q_stat_t stat_i,
  output logic             pop_o,
  utt_out_if.source        out_o
);
  import utt_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             has_q, last_q, send_q, bad_q;
  logic             load;
  logic             is_last;

  assign load = !stat_i.empty && (!valid_q || out_o.ready);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o = load && is_last;

  always_comb begin
    idx_d = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d = is_last ? '0 : idx_q + IdxW'(1);
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      has_q <= !head_i.bare;
      last_q <= is_last;
      send_q <= is_last && head_i.eos;
      bad_q <= head_i.bare;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.has_byte = has_q;
  assign out_o.last_of_run = last_q;
  assign out_o.string_end = send_q;
  assign out_o.bad_string = bad_q;

endmodule

>>> rtl/utf16_to_utf8_transcoder_top.sv
// Channel | Direction | Payload                                              | Handshake
// in_i    | sink      | code_unit[15:0], end_of_string                       | valid/ready
// out_o   | source    | out_byte[7:0], has_byte, last_of_run, string_end,    | valid/ready
//         |           | bad_string                                           |
//
// An item is accepted in any cycle in which the command queue has room; each item gives
// zero to four results, and the output register sends one result per cycle unless stalled;
// an item of n bytes (four at most) stays at the queue head until its last byte is loaded.
// With the queue and output register empty, an accepted item is written to the queue and
// its first result is then loaded from the queue head into the output register.
// The asynchronous reset clears the surrogate state, the queue pointers and the output valid.
// A stalled output holds its result; once the queue is full, input ready falls.
module utf16_to_utf8_transcoder_top #(
  parameter int unsigned QueueDepth = utt_pkg::QueueDepthDef
) (
  input logic    clk_i,
  input logic    rst_ni,
  utt_in_if.sink    in_i,
  utt_out_if.source out_o
);
  import utt_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t stat;
  logic    push;
  logic    pop;

  utt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  utt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (stat)
  );

  utt_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

>>> rtl/utt_checker.sv
module utt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  utt_out_if.source out_i
);

  // A stalled result keeps its valid.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_i.valid && !out_i.ready |=> out_i.valid)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_i.valid && !out_i.ready |=> $stable(out_i.out_byte) && $stable(out_i.has_byte)
      && $stable(out_i.string_end) && $stable(out_i.bad_string))
    else $error("output payload changed while stalled");

  // The bad-string status is a bare result that closes the string.
  a_bad_is_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_i.valid && (out_i.bad_string || !out_i.has_byte) |->
      !out_i.has_byte && out_i.bad_string && out_i.out_byte == 8'h00
      && out_i.last_of_run && out_i.string_end)
    else $error("malformed bad-string result");

  // The end of a string is always the last result of its item.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_i.valid && out_i.string_end |-> out_i.last_of_run)
    else $error("string end without last of run");

endmodule

bind utf16_to_utf8_transcoder_top utt_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_i  (out_o)
);
